// ----- design/cbfm_pkg.sv -----
// Shared constants and types of the clipped box filter mean block.
`timescale 1ns / 1ps
package cbfm_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 8;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 12;
    localparam int CFG_R_BITS    = 4;
    localparam int CFG_DATA_BITS = 12;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic last;
        logic eof;
    } t_res_tag;

endpackage

// ----- design/cbfm_div.sv -----
// Bit-serial restoring divider for three channel sums sharing one divisor.
`timescale 1ns / 1ps
module cbfm_div #(
    parameter int NUMW = 25,
    parameter int DENW = 9,
    parameter int QW   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [3*NUMW-1:0] i_num,
    input  logic [DENW-1:0]   i_den,
    output logic              o_done,
    output logic [3*QW-1:0]   o_quo
);
    localparam int CNTB = $clog2(NUMW + 1);

    logic [2:0][NUMW-1:0] r_num;
    logic [2:0][DENW-1:0] r_rem;
    logic [DENW-1:0]      r_den;
    logic [CNTB-1:0]      r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [2:0][DENW-1:0] n_rem;
    logic [2:0]           n_bit;
    logic [2:0][DENW:0]   w_try;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_try[k] = {r_rem[k], r_num[k][NUMW-1]};
            n_bit[k] = (w_try[k] >= {1'b0, r_den});
            n_rem[k] = n_bit[k] ? DENW'(w_try[k] - {1'b0, r_den}) : DENW'(w_try[k]);
        end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNTB'(NUMW);
            r_den  <= i_den;
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= i_num[k*NUMW +: NUMW];
                r_rem[k] <= '0;
            end
        end else if (r_busy) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= {r_num[k][NUMW-2:0], n_bit[k]};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNTB'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    always_comb begin
        for (int k = 0; k < 3; k++) o_quo[k*QW +: QW] = r_num[k][QW-1:0];
    end
endmodule

// ----- design/cbfm_ostage.sv -----
// Output register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps
module cbfm_ostage #(
    parameter int CHW = 16,
    parameter int TDW = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [3*CHW-1:0]    i_data,
    input  cbfm_pkg::t_res_tag  i_tag,
    output logic                o_free,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [TDW-1:0]      m_axis_tdata,   // red_avg, green_avg, blue_avg, zero pad
    output logic                m_axis_tlast,
    output logic                m_axis_tuser    // end_of_frame
);
    import cbfm_pkg::*;

    logic             r_valid;
    logic [3*CHW-1:0] r_data;
    t_res_tag         r_tag;

    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
            r_tag  <= i_tag;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = TDW'(r_data);
    assign m_axis_tlast  = r_tag.last;
    assign m_axis_tuser  = r_tag.eof;
endmodule

// ----- design/clipped_box_filter_mean.sv -----
// Clipped box filter mean: top level with sequencer, row store and column sum memories.
// One item is worked at a time; an item with no result only updates the memories and sums. Each
// result runs the bit-serial divider, and a further result at a row end first drops the leaving
// column sum from the window when its left edge has moved. Results wait while the output register
// is full. Synchronous active-low reset clears control and the registers to 640x480, radius 2; the
// memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module clipped_box_filter_mean #(
    parameter int MAX_WIDTH  = cbfm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = cbfm_pkg::DEF_MAX_RADIUS,
    parameter int FRAC_BITS  = cbfm_pkg::DEF_FRAC_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [cbfm_pkg::CFG_IDX_BITS-1:0]         i_cfg_index,
    input  logic [cbfm_pkg::CFG_DATA_BITS-1:0]        i_cfg_data,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((3*(8+FRAC_BITS)+7)/8)*8-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                                      s_axis_tuser,  // cmd
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [((3*(8+FRAC_BITS)+7)/8)*8-1:0]      m_axis_tdata,  // red, green, blue avg
    output logic                                      m_axis_tlast,  // last_of_run
    output logic                                      m_axis_tuser   // end_of_frame
);
    import cbfm_pkg::*;

    localparam int CHW   = 8 + FRAC_BITS;
    localparam int TDW   = ((3*CHW + 7) / 8) * 8;
    localparam int RING  = 2*MAX_RADIUS + 1;
    localparam int RIW   = $clog2(RING);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (WB > CFG_W_BITS) ? WB : CFG_W_BITS;
    localparam int RADW  = CFG_R_BITS;
    localparam int PW    = RADW + 1;
    localparam int HB    = CFG_H_BITS + 1;
    localparam int CSW   = CHW + $clog2(RING);
    localparam int WSW   = CHW + $clog2(RING*RING);
    localparam int CNTW  = $clog2(RING*RING + 1);
    localparam int SIDEW = $clog2(RING + 1);
    localparam int RSD   = RING * MAX_WIDTH;
    localparam int RSAW  = $clog2(RSD);
    localparam int RLIM  = (MAX_RADIUS < (MAX_WIDTH-1)/2) ? MAX_RADIUS : (MAX_WIDTH-1)/2;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPD    = 3'd1;
    localparam logic [2:0] ST_SUB_RD = 3'd2;
    localparam logic [2:0] ST_SUB    = 3'd3;
    localparam logic [2:0] ST_DIVGO  = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;

    logic [CFG_W_BITS-1:0] r_cfg_w;
    logic [CFG_H_BITS-1:0] r_cfg_h;
    logic [RADW-1:0]       r_cfg_r;

    logic [RADW-1:0]       g_r;
    logic [PW-1:0]         g_per;
    logic [EW-1:0]         t_w;
    logic [WB-1:0]         g_w;
    logic [CFG_H_BITS-1:0] g_h;

    logic [2:0]            r_state;
    logic [CW-1:0]         r_col;
    logic [HB-1:0]         r_row;
    logic [RIW-1:0]        r_ring;
    logic [2:0][CHW-1:0]   r_v;
    logic [2:0][WSW-1:0]   r_win;
    logic [CW-1:0]         r_x;
    logic [CW-1:0]         r_xlast;
    logic [SIDEW-1:0]      r_rows;
    logic                  r_ylast;

    logic [3*CHW-1:0]      rs_mem [RSD];
    logic [3*CSW-1:0]      cs_mem [MAX_WIDTH];
    logic [3*CHW-1:0]      r_rs_q;
    logic [3*CSW-1:0]      r_cs_qa;
    logic [3*CSW-1:0]      r_cs_qb;
    logic [RSAW-1:0]       rs_addr;
    logic [CW-1:0]         cs_addr_a;
    logic [CW-1:0]         cs_addr_b;
    logic                  mem_we;
    logic [3*CSW-1:0]      cs_wdata;

    logic [2:0][CSW-1:0]   n_cs;
    logic [2:0][WSW-1:0]   n_win;
    logic [CW-1:0]         w_last_col;
    logic                  at_row_end;
    logic                  out_go;
    logic [HB-1:0]         y_pos;
    logic [HB-1:0]         y_top;
    logic [HB-1:0]         y_bot;
    logic [CW:0]           x_left;
    logic [CW:0]           x_right;
    logic [SIDEW-1:0]      cols;
    logic [2*SIDEW-1:0]    area;
    logic [CW-1:0]         n_col;
    logic [HB-1:0]         n_row;
    logic [RIW-1:0]        n_ring;

    logic                  in_acc;
    logic                  div_start;
    logic                  div_done;
    logic [3*CHW-1:0]      div_quo;
    logic                  out_free;
    logic                  out_load;
    t_res_tag              out_tag;

    // Effective geometry; the radius is limited first, then width and height follow it.
    always_comb begin
        g_r = r_cfg_r;
        if (int'(r_cfg_r) > RLIM) g_r = RADW'(RLIM);
        g_per = {g_r, 1'b1};
        t_w = EW'(r_cfg_w);
        if (t_w < EW'(g_per)) t_w = EW'(g_per);
        if (t_w > EW'(MAX_WIDTH)) t_w = EW'(MAX_WIDTH);
        g_w = WB'(t_w);
        g_h = r_cfg_h;
        if (g_h < CFG_H_BITS'(g_per)) g_h = CFG_H_BITS'(g_per);
    end

    assign w_last_col = CW'(g_w - 1'b1);
    assign at_row_end = (r_col == w_last_col);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Column and window sum update for the item being worked.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_cs[k] = ((r_row == '0) ? CSW'(0) : r_cs_qa[k*CSW +: CSW])
                    + CSW'(r_v[k])
                    - ((r_row >= HB'(g_per)) ? CSW'(r_rs_q[k*CHW +: CHW]) : CSW'(0));
            n_win[k] = (r_col == '0) ? WSW'(n_cs[k])
                     : r_win[k] + WSW'(n_cs[k])
                       - ((r_col >= CW'(g_per)) ? WSW'(r_cs_qb[k*CSW +: CSW]) : WSW'(0));
            cs_wdata[k*CSW +: CSW] = n_cs[k];
        end
    end

    assign out_go = (r_row >= HB'(g_r)) && (r_col >= CW'(g_r));
    assign y_pos  = r_row - HB'(g_r);
    assign y_top  = (y_pos >= HB'(g_r)) ? y_pos - HB'(g_r) : '0;
    assign y_bot  = (y_pos + HB'(g_r) > HB'(g_h) - 1'b1) ? HB'(g_h) - 1'b1 : y_pos + HB'(g_r);

    assign x_left  = ({1'b0, r_x} >= (CW+1)'(g_r)) ? {1'b0, r_x} - (CW+1)'(g_r) : '0;
    assign x_right = ({1'b0, r_x} + (CW+1)'(g_r) > {1'b0, w_last_col})
                   ? {1'b0, w_last_col} : {1'b0, r_x} + (CW+1)'(g_r);
    assign cols = SIDEW'(x_right - x_left + 1'b1);
    assign area = r_rows * cols;

    // Raster position of the next item; drain rows run r rows past the frame.
    always_comb begin
        n_col  = r_col + 1'b1;
        n_row  = r_row;
        n_ring = r_ring;
        if (at_row_end) begin
            n_col = '0;
            if (r_row + 1'b1 >= HB'(g_h) + HB'(g_r)) begin
                n_row  = '0;
                n_ring = '0;
            end else begin
                n_row  = r_row + 1'b1;
                n_ring = (r_ring == RIW'(g_per - 1'b1)) ? '0 : r_ring + 1'b1;
            end
        end
    end

    assign rs_addr   = RSAW'(r_ring) * RSAW'(MAX_WIDTH) + RSAW'(r_col);
    assign cs_addr_a = (r_state == ST_SUB_RD) ? r_x - CW'(g_r) - 1'b1 : r_col;
    assign cs_addr_b = r_col - CW'(g_per);
    assign mem_we    = (r_state == ST_UPD);

    always_ff @(posedge i_clk) begin
        if (mem_we) rs_mem[rs_addr] <= {r_v[2], r_v[1], r_v[0]};
        r_rs_q <= rs_mem[rs_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) cs_mem[r_col] <= cs_wdata;
        r_cs_qa <= cs_mem[cs_addr_a];
        r_cs_qb <= cs_mem[cs_addr_b];
    end

    assign div_start = (r_state == ST_DIVGO);
    assign out_load  = (r_state == ST_DIV) && div_done && out_free;
    assign out_tag.last = (r_x == r_xlast);
    assign out_tag.eof  = (r_x == w_last_col) && r_ylast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W_BITS'(640);
            r_cfg_h <= CFG_H_BITS'(480);
            r_cfg_r <= RADW'(2);
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_ring  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_BITS-1:0];
                REG_HEIGHT: r_cfg_h <= i_cfg_data[CFG_H_BITS-1:0];
                REG_RADIUS: r_cfg_r <= i_cfg_data[RADW-1:0];
                default: ;
            endcase
            if (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT
                || i_cfg_index == REG_RADIUS) begin
                r_col  <= '0;
                r_row  <= '0;
                r_ring <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (out_go) begin
                        r_state <= ST_DIVGO;
                    end else begin
                        r_state <= ST_IDLE;
                        r_col   <= n_col;
                        r_row   <= n_row;
                        r_ring  <= n_ring;
                    end
                end
                ST_SUB_RD: r_state <= ST_SUB;
                ST_SUB:    r_state <= ST_DIVGO;
                ST_DIVGO:  r_state <= ST_DIV;
                ST_DIV: begin
                    if (out_load) begin
                        if (r_x == r_xlast) begin
                            r_state <= ST_IDLE;
                            r_col   <= n_col;
                            r_row   <= n_row;
                            r_ring  <= n_ring;
                        end else if (r_x >= CW'(g_r)) begin
                            r_state <= ST_SUB_RD;
                        end else begin
                            r_state <= ST_DIVGO;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers of the item in flight.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < 3; k++) begin
                r_v[k] <= (r_row < HB'(g_h) && s_axis_tuser == CMD_PIXEL)
                        ? s_axis_tdata[k*CHW +: CHW] : '0;
            end
        end
        if (r_state == ST_UPD) begin
            r_win   <= n_win;
            r_x     <= r_col - CW'(g_r);
            r_xlast <= at_row_end ? r_col : r_col - CW'(g_r);
            r_rows  <= SIDEW'(y_bot - y_top + 1'b1);
            r_ylast <= (y_pos == HB'(g_h) - 1'b1);
        end
        if (r_state == ST_SUB) begin
            for (int k = 0; k < 3; k++) r_win[k] <= r_win[k] - WSW'(r_cs_qa[k*CSW +: CSW]);
        end
        if (out_load && r_x != r_xlast) r_x <= r_x + 1'b1;
    end

    cbfm_div #(
        .NUMW (WSW),
        .DENW (CNTW),
        .QW   (CHW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_win[2], r_win[1], r_win[0]}),
        .i_den   (CNTW'(area)),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    cbfm_ostage #(
        .CHW (CHW),
        .TDW (TDW)
    ) u_ostage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_data        (div_quo),
        .i_tag         (out_tag),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WB'(r_col) < g_w)
        else $error("column counter beyond the row width");

    a_ring_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_ring) < g_per)
        else $error("row ring index beyond the window period");

    a_accept_updates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_cfg_we |=> r_state == ST_UPD)
        else $error("accepted request was not followed by the memory update");

    a_result_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && !out_tag.last && !i_cfg_we |=> r_x == $past(r_x) + 1'b1)
        else $error("result column did not advance within a run");
endmodule
